// ===== sv/tcpq_pkg.sv =====
// Shared types and constants for the two-class priority packet queue.
// No dependencies; compiled first.
package tcpq_pkg;

  localparam int OPC_W = 2;
  localparam int CAP_W = 5;
  localparam int CNT_OUT_W = 5;

  localparam logic [OPC_W-1:0] OP_PUSH  = 2'd0;
  localparam logic [OPC_W-1:0] OP_POP   = 2'd1;
  localparam logic [OPC_W-1:0] OP_CLEAR = 2'd2;

  localparam logic STATUS_DONE     = 1'b0;
  localparam logic STATUS_OVERFLOW = 1'b1;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } ctrl_state_t;

  typedef struct packed {
    logic load_in;
    logic execute;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_status_t;

endpackage

// ===== sv/tcpq_in_if.sv =====
// Request channel: valid/ready plus one operation word.
// Depends on tcpq_pkg.
interface tcpq_in_if #(
  parameter int TAG_WIDTH = 16
);
  logic                       valid;
  logic                       ready;
  logic [tcpq_pkg::OPC_W-1:0] opcode;
  logic [TAG_WIDTH-1:0]       packet_tag;
  logic                       urgent;

  modport source (output valid, output opcode, output packet_tag, output urgent,
                  input ready);
  modport sink   (input valid, input opcode, input packet_tag, input urgent,
                  output ready);
endinterface

// ===== sv/tcpq_out_if.sv =====
// Response channel: valid/ready plus one result word.
// Depends on tcpq_pkg.
interface tcpq_out_if #(
  parameter int TAG_WIDTH = 16
);
  logic                           valid;
  logic                           ready;
  logic                           status;
  logic                           popped_valid;
  logic [TAG_WIDTH-1:0]           popped_tag;
  logic                           popped_urgent;
  logic                           evicted_valid;
  logic [TAG_WIDTH-1:0]           evicted_tag;
  logic [tcpq_pkg::CNT_OUT_W-1:0] entry_count;
  logic                           is_empty;

  modport source (output valid, output status, output popped_valid, output popped_tag,
                  output popped_urgent, output evicted_valid, output evicted_tag,
                  output entry_count, output is_empty, input ready);
  modport sink   (input valid, input status, input popped_valid, input popped_tag,
                  input popped_urgent, input evicted_valid, input evicted_tag,
                  input entry_count, input is_empty, output ready);
endinterface

// ===== sv/tcpq_ctrl.sv =====
// Controller for the priority queue: accepts a word, then executes it
// once the output register is free. Depends on tcpq_pkg.
module tcpq_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  tcpq_pkg::dp_status_t stat,
  output tcpq_pkg::ctrl_cmd_t  cmd
);
  import tcpq_pkg::*;

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    in_ready    = 1'b0;
    cmd.load_in = 1'b0;
    cmd.execute = 1'b0;
    unique case (state)
      ST_IDLE: begin
        // refuse words while reset is held
        if (!rst) begin
          in_ready = 1'b1;
          if (in_valid) begin
            cmd.load_in = 1'b1;
            state_next  = ST_EXEC;
          end
        end
      end
      ST_EXEC: begin
        // hold until the previous result has been taken
        if (stat.out_free) begin
          cmd.execute = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// ===== sv/tcpq_dp.sv =====
// Datapath: two circular tag stores, heads, counts, limit register and
// the result register. Depends on tcpq_pkg.
module tcpq_dp #(
  parameter int QUEUE_DEPTH = 16,
  parameter int TAG_WIDTH   = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  tcpq_pkg::ctrl_cmd_t            cmd,
  output tcpq_pkg::dp_status_t           stat,
  input  logic                           cfg_we,
  input  logic [tcpq_pkg::CAP_W-1:0]     cfg_wdata,
  input  logic [tcpq_pkg::OPC_W-1:0]     in_opcode,
  input  logic [TAG_WIDTH-1:0]           in_tag,
  input  logic                           in_urgent,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_status,
  output logic                           out_popped_valid,
  output logic [TAG_WIDTH-1:0]           out_popped_tag,
  output logic                           out_popped_urgent,
  output logic                           out_evicted_valid,
  output logic [TAG_WIDTH-1:0]           out_evicted_tag,
  output logic [tcpq_pkg::CNT_OUT_W-1:0] out_entry_count,
  output logic                           out_is_empty
);
  import tcpq_pkg::*;

  localparam int ADDR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int SLOT_W = CNT_W + 1;
  localparam int SUM_W  = (CNT_W + 1 > CAP_W) ? CNT_W + 1 : CAP_W;

  logic [TAG_WIDTH-1:0] urgent_store [QUEUE_DEPTH];
  logic [TAG_WIDTH-1:0] normal_store [QUEUE_DEPTH];

  logic [ADDR_W-1:0] urgent_head, normal_head;
  logic [CNT_W-1:0]  urgent_count, normal_count;
  logic [CAP_W-1:0]  capacity_limit;

  logic [OPC_W-1:0]     op_q;
  logic [TAG_WIDTH-1:0] tag_q;
  logic                 urg_q;

  logic [TAG_WIDTH-1:0] urgent_rd, normal_rd;

  logic [ADDR_W-1:0] urgent_head_next, normal_head_next;
  logic [CNT_W-1:0]  urgent_count_next, normal_count_next;
  logic              urgent_we, normal_we;
  logic [ADDR_W-1:0] urgent_waddr, normal_waddr;

  logic [SUM_W-1:0]  total, total_after, limit_eff;
  logic [SLOT_W-1:0] urgent_sum, normal_sum;

  logic                 r_status, r_pv, r_purg, r_ev;
  logic [TAG_WIDTH-1:0] r_ptag, r_etag;

  function automatic logic [ADDR_W-1:0] head_inc(input logic [ADDR_W-1:0] h);
    head_inc = (h == ADDR_W'(QUEUE_DEPTH - 1)) ? '0 : h + 1'b1;
  endfunction

  assign stat.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity_limit <= CAP_RESET;
    end else if (cfg_we) begin
      capacity_limit <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_q  <= in_opcode;
      tag_q <= in_tag;
      urg_q <= in_urgent;
    end
  end

  // head reads are registered every cycle; heads only move in the execute cycle
  always_ff @(posedge clk) begin
    urgent_rd <= urgent_store[urgent_head];
    normal_rd <= normal_store[normal_head];
    if (urgent_we) begin
      urgent_store[urgent_waddr] <= tag_q;
    end
    if (normal_we) begin
      normal_store[normal_waddr] <= tag_q;
    end
  end

  // tail slot is head + count; after an eviction the normal tail lands on the same slot
  always_comb begin
    urgent_sum   = SLOT_W'(urgent_head) + SLOT_W'(urgent_count);
    normal_sum   = SLOT_W'(normal_head) + SLOT_W'(normal_count);
    if (urgent_sum >= SLOT_W'(QUEUE_DEPTH)) begin
      urgent_sum = urgent_sum - SLOT_W'(QUEUE_DEPTH);
    end
    if (normal_sum >= SLOT_W'(QUEUE_DEPTH)) begin
      normal_sum = normal_sum - SLOT_W'(QUEUE_DEPTH);
    end
    urgent_waddr = urgent_sum[ADDR_W-1:0];
    normal_waddr = normal_sum[ADDR_W-1:0];
  end

  always_comb begin
    priority if (capacity_limit == '0) begin
      limit_eff = SUM_W'(1);
    end else if (SUM_W'(capacity_limit) > SUM_W'(QUEUE_DEPTH)) begin
      limit_eff = SUM_W'(QUEUE_DEPTH);
    end else begin
      limit_eff = SUM_W'(capacity_limit);
    end
  end

  assign total = SUM_W'(urgent_count) + SUM_W'(normal_count);

  always_comb begin
    urgent_head_next  = urgent_head;
    normal_head_next  = normal_head;
    urgent_count_next = urgent_count;
    normal_count_next = normal_count;
    urgent_we         = 1'b0;
    normal_we         = 1'b0;
    r_status          = STATUS_DONE;
    r_pv              = 1'b0;
    r_ptag            = '0;
    r_purg            = 1'b0;
    r_ev              = 1'b0;
    r_etag            = '0;
    if (cmd.execute) begin
      unique case (op_q)
        OP_PUSH: begin
          if (total < limit_eff || normal_count != '0) begin
            if (total >= limit_eff) begin
              // drop the oldest normal entry to make room
              r_ev              = 1'b1;
              r_etag            = normal_rd;
              normal_head_next  = head_inc(normal_head);
              normal_count_next = normal_count - 1'b1;
            end
            if (urg_q) begin
              if (urgent_count < CNT_W'(QUEUE_DEPTH)) begin
                urgent_we         = 1'b1;
                urgent_count_next = urgent_count + 1'b1;
              end
            end else if (normal_count_next < CNT_W'(QUEUE_DEPTH)) begin
              normal_we         = 1'b1;
              normal_count_next = normal_count_next + 1'b1;
            end
          end else begin
            r_status = STATUS_OVERFLOW;
          end
        end
        OP_POP: begin
          priority if (urgent_count != '0) begin
            r_pv              = 1'b1;
            r_purg            = 1'b1;
            r_ptag            = urgent_rd;
            urgent_head_next  = head_inc(urgent_head);
            urgent_count_next = urgent_count - 1'b1;
          end else if (normal_count != '0) begin
            r_pv              = 1'b1;
            r_ptag            = normal_rd;
            normal_head_next  = head_inc(normal_head);
            normal_count_next = normal_count - 1'b1;
          end
        end
        OP_CLEAR: begin
          urgent_head_next  = '0;
          normal_head_next  = '0;
          urgent_count_next = '0;
          normal_count_next = '0;
        end
        default: begin
        end
      endcase
    end
    total_after = SUM_W'(urgent_count_next) + SUM_W'(normal_count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      urgent_head  <= '0;
      normal_head  <= '0;
      urgent_count <= '0;
      normal_count <= '0;
    end else begin
      urgent_head  <= urgent_head_next;
      normal_head  <= normal_head_next;
      urgent_count <= urgent_count_next;
      normal_count <= normal_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.execute) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      out_status        <= r_status;
      out_popped_valid  <= r_pv;
      out_popped_tag    <= r_ptag;
      out_popped_urgent <= r_purg;
      out_evicted_valid <= r_ev;
      out_evicted_tag   <= r_etag;
      out_entry_count   <= total_after[CNT_OUT_W-1:0];
      out_is_empty      <= (total_after == '0);
    end
  end

endmodule

// ===== sv/two_class_priority_packet_queue_core.sv =====
// Top level of the two-class priority packet queue.
// Depends on tcpq_pkg, tcpq_in_if, tcpq_out_if, tcpq_ctrl and tcpq_dp.
//
//   port       dir  handshake          carries
//   req        in   valid/ready        opcode, packet_tag, urgent
//   rsp        out  valid/ready        one result word per request word
//   cfg_we     in   write strobe       capacity_limit written from cfg_wdata
//
// A request word is accepted, then executed into the result register.
// The stores are read through registered head ports.
// A result still waiting on rsp does not block the next accept; it stalls execute.
// Synchronous active-high reset empties both classes and sets the limit to 16.
module two_class_priority_packet_queue_core #(
  parameter int QUEUE_DEPTH = 16,
  parameter int TAG_WIDTH   = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [tcpq_pkg::CAP_W-1:0] cfg_wdata,
  tcpq_in_if.sink                    req,
  tcpq_out_if.source                 rsp
);
  import tcpq_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t stat;

  tcpq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  tcpq_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .TAG_WIDTH   (TAG_WIDTH)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .stat              (stat),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .in_opcode         (req.opcode),
    .in_tag            (req.packet_tag),
    .in_urgent         (req.urgent),
    .out_valid         (rsp.valid),
    .out_ready         (rsp.ready),
    .out_status        (rsp.status),
    .out_popped_valid  (rsp.popped_valid),
    .out_popped_tag    (rsp.popped_tag),
    .out_popped_urgent (rsp.popped_urgent),
    .out_evicted_valid (rsp.evicted_valid),
    .out_evicted_tag   (rsp.evicted_tag),
    .out_entry_count   (rsp.entry_count),
    .out_is_empty      (rsp.is_empty)
  );

endmodule
